// File: sv/isr_pkg.sv
// Shared types and constants for the integer square root block.
package isr_pkg;

	// Width of the root field on the result channel.
	localparam int ROOT_WIDTH = 16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture a new operand, clear the iteration
		logic step;   // resolve one root bit
		logic emit;   // copy the finished root into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;   // the step in progress resolves the lowest root bit
	} sts_t;

endpackage

// File: sv/isr_channels.sv
// Valid/ready stream interfaces for the operand and the root channels.
interface isr_value_if #(
	parameter int W = 32
);
	logic         valid;
	logic         ready;
	logic [W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface isr_root_if;
	logic                           valid;
	logic                           ready;
	logic [isr_pkg::ROOT_WIDTH-1:0] root;

	modport source (output valid, output root, input ready);
	modport sink (input valid, input root, output ready);
endinterface

// File: sv/isr_datapath.sv
// Datapath: operand shifter, remainder, partial root, step counter, output register.
module isr_datapath #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  isr_pkg::cmd_t                  cmd,
	output isr_pkg::sts_t                  sts,
	input  logic [OPERAND_WIDTH-1:0]       value,
	output logic [isr_pkg::ROOT_WIDTH-1:0] root
);

	localparam int RW = (OPERAND_WIDTH + 1) / 2;
	localparam int XW = 2 * RW;
	localparam int CW = $clog2(RW);

	logic [XW-1:0]                  x_q;
	logic [RW:0]                    rem_q;
	logic [RW-1:0]                  root_q;
	logic [CW-1:0]                  cnt_q;
	logic [isr_pkg::ROOT_WIDTH-1:0] root_out_q;

	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic [RW+1:0] diff;
	logic          ge;

	// Bring down the next operand bit pair and try a one in the next root bit.
	assign rem_sh = {rem_q[RW-1:0], x_q[XW-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign diff   = rem_sh - trial;

	assign sts.last = cnt_q == '0;
	assign root     = root_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= CW'(RW - 1);
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// Negative operands take the zero path.
			x_q    <= value[OPERAND_WIDTH-1] ? '0 : XW'(value);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.step) begin
			x_q    <= x_q << 2;
			rem_q  <= ge ? diff[RW:0] : rem_sh[RW:0];
			root_q <= {root_q[RW-2:0], ge};
		end
		if (cmd.emit) begin
			root_out_q <= isr_pkg::ROOT_WIDTH'(root_q);
		end
	end

endmodule

// File: sv/isr_ctrl.sv
// Controller: sequences load, bit steps and hand-off to the output register.
module isr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  isr_pkg::sts_t sts,
	output isr_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (sts.last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// Hand off the root and take the next operand in the same cycle.
				if (slot_free) begin
					cmd.emit = 1'b1;
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = ST_RUN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("root emitted over an untaken result");

	a_no_load_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !cmd.load && !in_ready)
		else $error("operand taken while an iteration is in progress");

	a_last_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && sts.last) |=> (state_q == ST_FIN))
		else $error("last step did not lead to hand-off");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted root not presented");
`endif

endmodule

// File: sv/integer_square_root.sv
// Sequence: the operand transfer loads the datapath, the run state resolves the root bits
// with the shared remainder compare/subtract at one root bit per cycle, and the finish
// state hands the root on once the output register is free; operands are taken only there or in idle.
// A finished root waits in the output register while the next operand is taken.
// Reset: arst_n clears the controller state, the step counter and the output valid at once; data
// registers are not reset.
module integer_square_root #(
	parameter int OPERAND_WIDTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	isr_value_if.sink   operand,
	isr_root_if.source  result
);

	// Command and status between controller and datapath.
	isr_pkg::cmd_t cmd;
	isr_pkg::sts_t sts;

	// Controller: owns both handshakes and the sequencing of bit steps.
	isr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operand.valid),
		.in_ready  (operand.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: digit-by-digit root with a shift-and-subtract remainder.
	// Each step brings down two operand bits and keeps a root bit of one
	// when the remainder covers the trial value; non-positive operands
	// collapse to zero at load and so give a root of zero.
	isr_datapath #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.value  (operand.value),
		.root   (result.root)
	);

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the integer square root block: directed table, then random operands.
module testbench;

	localparam int OPERAND_WIDTH = 32;
	localparam int RANDOM_ITEMS  = 630;
	localparam int IDLE_PERCENT  = 26;
	localparam int DRAIN_CYCLES  = 40;

	// One row of the directed table. With has_root set, the root is typed in;
	// otherwise the predictor supplies it.
	typedef struct packed {
		logic [OPERAND_WIDTH-1:0]       value;
		logic                           has_root;
		logic [isr_pkg::ROOT_WIDTH-1:0] root;
	} directed_row_t;

	// One outstanding root, kept with its operand for the mismatch report.
	typedef struct packed {
		logic [OPERAND_WIDTH-1:0]       value;
		logic [isr_pkg::ROOT_WIDTH-1:0] root;
	} pending_root_t;

	logic clk;
	logic arst_n;

	isr_value_if #(.W(OPERAND_WIDTH)) operand_ch ();
	isr_root_if                       result_ch ();

	integer_square_root #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand_ch),
		.result (result_ch)
	);

	// Roots owed by the block, oldest first.
	pending_root_t pending_roots[$];

	int mismatches    = 0;
	int sent_count    = 0;
	int checked_count = 0;
	int squares_sent  = 0;
	int negative_sent = 0;

	// While set, neither side idles.
	logic steady = 1'b0;

	// Directed operands: zero, one, small values, powers of two, the neighbors of
	// the largest perfect square, the largest positive value and negative values.
	directed_row_t directed_rows [0:19] = '{
		'{32'd0,          1'b1, 16'd0},
		'{32'd1,          1'b1, 16'd1},
		'{32'd2,          1'b0, 16'd0},
		'{32'd3,          1'b0, 16'd0},
		'{32'd4,          1'b1, 16'd2},
		'{32'd5,          1'b0, 16'd0},
		'{32'd99,         1'b0, 16'd0},
		'{32'd100,        1'b1, 16'd10},
		'{32'd65535,      1'b0, 16'd0},
		'{32'd65536,      1'b1, 16'd256},
		'{32'h3FFF_FFFF,  1'b0, 16'd0},
		'{32'h4000_0000,  1'b1, 16'd32768},
		'{32'd2147395599, 1'b0, 16'd0},
		'{32'd2147395600, 1'b1, 16'd46340},
		'{32'h7FFF_FFFE,  1'b0, 16'd0},
		'{32'h7FFF_FFFF,  1'b1, 16'd46340},
		'{32'h8000_0000,  1'b1, 16'd0},
		'{32'hFFFF_FFFF,  1'b1, 16'd0},
		'{32'hAAAA_AAAA,  1'b1, 16'd0},
		'{32'h5555_5555,  1'b0, 16'd0}
	};

	// Free-running clock, period 2.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Floor square root: non-positive operands give zero; otherwise resolve root
	// bits from the top down, keeping a bit only while its square fits.
	function automatic logic [isr_pkg::ROOT_WIDTH-1:0] floor_root_of(
			logic [OPERAND_WIDTH-1:0] value);
		logic [31:0] root_acc;
		logic [31:0] trial;
		logic [63:0] trial_sq;
		root_acc = 32'd0;
		if (value[OPERAND_WIDTH-1] || value == '0)
			return '0;
		for (int b = isr_pkg::ROOT_WIDTH - 1; b >= 0; b--) begin
			trial    = root_acc | (32'd1 << b);
			trial_sq = trial * trial;
			if (trial_sq <= {32'd0, value})
				root_acc = trial;
		end
		return root_acc[isr_pkg::ROOT_WIDTH-1:0];
	endfunction

	// Draw one random operand from a mix of shapes: full range (half negative),
	// positive only, small, perfect squares and their neighbors, and scaled-down
	// values so that every root size shows up.
	function automatic logic [OPERAND_WIDTH-1:0] random_operand();
		logic [31:0] base;
		logic [31:0] square;
		base = $urandom_range(0, 46340);
		square = base * base;
		case ($urandom_range(0, 7))
			0, 1:    return $urandom();
			2:       return {1'b0, 31'($urandom())};
			3:       return $urandom_range(0, 1000);
			4:       return square;
			5:       return square - 32'd1;
			6:       return square + 32'd1;
			default: return {1'b0, 31'($urandom())} >> $urandom_range(0, 30);
		endcase
	endfunction

	// Sender idling: drop valid for a random number of cycles. Call at a falling edge.
	task automatic idle_sender();
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PERCENT) begin
				operand_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
	endtask

	// Offer one operand, hold it until the transfer, then log the root it owes.
	// Starts and ends at a falling edge.
	task automatic send_operand(logic [OPERAND_WIDTH-1:0] value, logic has_root,
			logic [isr_pkg::ROOT_WIDTH-1:0] typed_root);
		pending_root_t owed;
		operand_ch.valid <= 1'b1;
		operand_ch.value <= value;
		@(posedge clk);
		while (!operand_ch.ready)
			@(posedge clk);
		owed.value = value;
		owed.root  = has_root ? typed_root : floor_root_of(value);
		pending_roots.push_back(owed);
		sent_count++;
		if (value[OPERAND_WIDTH-1])
			negative_sent++;
		@(negedge clk);
		idle_sender();
	endtask

	// Receiver idling: lower ready in about a quarter of the cycles.
	always @(negedge clk) begin
		result_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	// Check each root transfer against the oldest owed root.
	always @(posedge clk) begin
		pending_root_t owed;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_roots.size() == 0) begin
				$display("%0t: unexpected root transfer: expected none, got %0d",
					$time, result_ch.root);
				mismatches++;
			end else begin
				owed = pending_roots.pop_front();
				checked_count++;
				if (result_ch.root !== owed.root) begin
					$display("%0t: root mismatch for operand 0x%08h: expected %0d, got %0d",
						$time, owed.value, owed.root, result_ch.root);
					mismatches++;
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [OPERAND_WIDTH-1:0] value;
		operand_ch.valid = 1'b0;
		operand_ch.value = '0;
		result_ch.ready  = 1'b0;
		arst_n           = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table.
		foreach (directed_rows[i])
			send_operand(directed_rows[i].value, directed_rows[i].has_root,
				directed_rows[i].root);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Hold a long stretch with no idling on either side.
			if (n == 250)
				steady <= 1'b1;
			if (n == 350)
				steady <= 1'b0;
			// Once, starve the block: hold off until every owed root has come back.
			if (n == 200) begin
				operand_ch.valid <= 1'b0;
				while (pending_roots.size() != 0)
					@(negedge clk);
			end
			value = random_operand();
			if (value != 32'd0 && !value[OPERAND_WIDTH-1] && floor_root_of(value) ** 2 == value)
				squares_sent++;
			send_operand(value, 1'b0, '0);
		end
		operand_ch.valid <= 1'b0;

		// Drain, then give the block time to show any stray transfer.
		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d operands (%0d negative, %0d nonzero perfect squares)",
			sent_count, negative_sent, squares_sent);
		$display("%0d roots checked; both sides idled at random, with one no-idle stretch",
			checked_count);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog: end a hung run.
	initial begin
		#1000000;
		$display("%0t: timeout with %0d roots still owed", $time, pending_roots.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
